[rtl/core/sixteen_bit_cpu_execute_subset_macros.svh]
// Assertion macros for the execute block checker.
// Depends on signals named clk and rst in the scope of each use.
`ifndef SIXTEEN_BIT_CPU_EXECUTE_SUBSET_MACROS_SVH
`define SIXTEEN_BIT_CPU_EXECUTE_SUBSET_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CPUX_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("execute block assertion failed");

// Next-cycle implication, disabled during reset.
`define CPUX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("execute block assertion failed");

`endif

[rtl/core/cpux_pkg.sv]
// Shared types, codes and register-file helpers for the execute block.
// No dependencies.
`default_nettype none

package cpux_pkg;

  localparam int MEM_ADDR_BITS_DEF = 16;

  typedef logic [15:0] word_t;
  typedef logic [7:0][15:0] gpr_t;
  typedef logic [3:0][15:0] seg_t;

  typedef enum logic [3:0] {
    CMD_MOV_RM      = 4'd0,
    CMD_ADD_RM      = 4'd1,
    CMD_SUB_RM      = 4'd2,
    CMD_CMP_RM      = 4'd3,
    CMD_MOV_IMM_REG = 4'd4,
    CMD_ADD_IMM_ACC = 4'd5,
    CMD_SUB_IMM_ACC = 4'd6,
    CMD_CMP_IMM_ACC = 4'd7,
    CMD_MOV_IMM_RM  = 4'd8,
    CMD_ADD_IMM_RM  = 4'd9,
    CMD_SUB_IMM_RM  = 4'd10,
    CMD_CMP_IMM_RM  = 4'd11,
    CMD_SEG_MOV     = 4'd12,
    CMD_JNE         = 4'd13
  } cmd_t;

  typedef enum logic [1:0] {
    OP_MOV = 2'd0,
    OP_ADD = 2'd1,
    OP_SUB = 2'd2,
    OP_CMP = 2'd3
  } alu_op_t;

  localparam logic [1:0] MODE_REG = 2'd3;
  localparam logic [2:0] REG_AX = 3'd0;
  localparam logic [2:0] REG_BX = 3'd3;
  localparam logic [2:0] REG_BP = 3'd5;
  localparam logic [2:0] REG_SI = 3'd6;
  localparam logic [2:0] REG_DI = 3'd7;

  // One decoded instruction as captured from the input channel.
  typedef struct packed {
    logic [3:0]  command;
    logic        to_register;
    logic        wide;
    logic [1:0]  mode;
    logic        direct_address;
    logic [2:0]  reg_index;
    logic [2:0]  rm_index;
    logic [1:0]  seg_index;
    logic [15:0] displacement;
    logic [15:0] immediate;
  } item_t;

  // Architectural update computed by the execute unit.
  typedef struct packed {
    gpr_t  gpr;
    seg_t  seg;
    logic  zf;
    logic  sf;
    word_t ip;
    word_t value;
    logic  mem_we;
    logic  taken;
  } exec_t;

  // Byte form maps 0..3 to low halves and 4..7 to high halves of 0..3.
  function automatic word_t reg_read(gpr_t g, logic [2:0] idx, logic wide);
    word_t v;
    if (wide) v = g[idx];
    else if (!idx[2]) v = {8'h00, g[idx][7:0]};
    else v = {8'h00, g[{1'b0, idx[1:0]}][15:8]};
    return v;
  endfunction

  function automatic gpr_t reg_write(gpr_t g, logic [2:0] idx, logic wide, word_t v);
    gpr_t r;
    r = g;
    if (wide) r[idx] = v;
    else if (!idx[2]) r[idx][7:0] = v[7:0];
    else r[{1'b0, idx[1:0]}][15:8] = v[7:0];
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/cpux_if.sv]
// Valid/ready channel interfaces for instructions and results.
// No dependencies.
`default_nettype none

interface cpux_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  command;
  logic        to_register;
  logic        wide;
  logic [1:0]  mode;
  logic        direct_address;
  logic [2:0]  reg_index;
  logic [2:0]  rm_index;
  logic [1:0]  seg_index;
  logic [15:0] displacement;
  logic [15:0] immediate;

  modport source (output valid, command, to_register, wide, mode, direct_address,
                  reg_index, rm_index, seg_index, displacement, immediate,
                  input ready);
  modport sink (input valid, command, to_register, wide, mode, direct_address,
                reg_index, rm_index, seg_index, displacement, immediate,
                output ready);
endinterface

interface cpux_out_if;
  logic        valid;
  logic        ready;
  logic        zero_flag;
  logic        sign_flag;
  logic [15:0] written_value;
  logic        branch_taken;
  logic [15:0] ip_value;

  modport source (output valid, zero_flag, sign_flag, written_value, branch_taken,
                  ip_value, input ready);
  modport sink (input valid, zero_flag, sign_flag, written_value, branch_taken,
                ip_value, output ready);
endinterface

`default_nettype wire

[rtl/core/cpux_ram.sv]
// Single-port byte data memory with a registered read.
// No dependencies.
`default_nettype none

module cpux_ram #(
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [2**AW];

  // Write and read share one address each cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

[rtl/core/cpux_alu.sv]
// Execute unit: computes the architectural update for one instruction.
// Depends on cpux_pkg.
`default_nettype none

module cpux_alu (
  input  cpux_pkg::item_t item,
  input  cpux_pkg::gpr_t  gpr,
  input  cpux_pkg::seg_t  seg,
  input  logic            zf,
  input  logic            sf,
  input  cpux_pkg::word_t ip,
  input  cpux_pkg::word_t mem_word,
  output cpux_pkg::exec_t res
);
  import cpux_pkg::*;

  logic       rm_mem;
  logic       act;
  logic       dst_rm;
  logic [2:0] dst_idx;
  alu_op_t    op;
  word_t      mem_v, rm_v, reg_v, imm_v, mask, sbit, a, b, r;

  always_comb begin
    rm_mem  = item.direct_address || (item.mode != MODE_REG);
    mem_v   = item.wide ? mem_word : {8'h00, mem_word[7:0]};
    rm_v    = rm_mem ? mem_v : reg_read(gpr, item.rm_index, item.wide);
    reg_v   = reg_read(gpr, item.reg_index, item.wide);
    imm_v   = item.wide ? item.immediate : {8'h00, item.immediate[7:0]};
    mask    = item.wide ? 16'hffff : 16'h00ff;
    sbit    = item.wide ? 16'h8000 : 16'h0080;
    act     = 1'b0;
    dst_rm  = 1'b0;
    dst_idx = item.reg_index;
    op      = OP_MOV;
    a       = '0;
    b       = '0;
    r       = '0;
    res.gpr    = gpr;
    res.seg    = seg;
    res.zf     = zf;
    res.sf     = sf;
    res.ip     = ip;
    res.value  = '0;
    res.mem_we = 1'b0;
    res.taken  = 1'b0;

    // Select operands and destination by command.
    case (cmd_t'(item.command))
      CMD_MOV_RM, CMD_ADD_RM, CMD_SUB_RM, CMD_CMP_RM: begin
        act = 1'b1;
        op  = alu_op_t'(item.command[1:0]);
        if (item.to_register) begin
          a = reg_v;
          b = rm_v;
        end else begin
          dst_rm = 1'b1;
          a = rm_v;
          b = reg_v;
        end
      end
      CMD_MOV_IMM_REG: begin
        act = 1'b1;
        b   = imm_v;
      end
      CMD_ADD_IMM_ACC, CMD_SUB_IMM_ACC, CMD_CMP_IMM_ACC: begin
        act     = 1'b1;
        op      = alu_op_t'(item.command[1:0]);
        dst_idx = REG_AX;
        a       = reg_read(gpr, REG_AX, item.wide);
        b       = imm_v;
      end
      CMD_MOV_IMM_RM: begin
        act    = 1'b1;
        dst_rm = 1'b1;
        b      = imm_v;
      end
      CMD_ADD_IMM_RM, CMD_SUB_IMM_RM, CMD_CMP_IMM_RM: begin
        act    = 1'b1;
        op     = alu_op_t'(item.command[1:0]);
        dst_rm = 1'b1;
        a      = rm_v;
        b      = imm_v;
      end
      CMD_SEG_MOV: begin
        if (!rm_mem) begin
          if (item.to_register) begin
            res.seg[item.seg_index] = gpr[item.rm_index];
            res.value = gpr[item.rm_index];
          end else begin
            res.gpr[item.rm_index] = seg[item.seg_index];
            res.value = seg[item.seg_index];
          end
        end
      end
      CMD_JNE: begin
        if (!zf) begin
          res.ip    = ip + {{8{item.immediate[7]}}, item.immediate[7:0]};
          res.taken = 1'b1;
        end
      end
      default: ;
    endcase

    // Arithmetic, flags and write-back for the move and arithmetic forms.
    if (act) begin
      if (op == OP_MOV) r = b;
      else if (op == OP_ADD) r = (a + b) & mask;
      else r = (a - b) & mask;
      res.value = r;
      if (op != OP_MOV) begin
        res.zf = (r == 16'h0000);
        res.sf = |(r & sbit);
      end
      if (op != OP_CMP) begin
        if (dst_rm && rm_mem) begin
          res.mem_we = 1'b1;
        end else begin
          res.gpr = reg_write(gpr, dst_rm ? item.rm_index : dst_idx, item.wide, r);
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/sixteen_bit_cpu_execute_subset.sv]
// Top level of the execute block: sequencer, register state and data memory.
// Depends on cpux_pkg, cpux_if, cpux_ram and cpux_alu.
//
//   channel  direction  carries
//   in_ch    sink       one decoded instruction per transaction
//   out_ch   source     flags, written value, branch and IP per transaction
//
// After acceptance an instruction passes through address add, two byte reads and a
// capture on the single memory port, execute with the low byte write, then the high
// byte write, before the next instruction is accepted.
// After reset the memory is cleared one byte a cycle, all 2**MEM_ADDR_BITS bytes,
// with in_ch.ready low. Reset is synchronous and active high.
// A result waits in the output register; execute stalls only while it is still held.
`default_nettype none

module sixteen_bit_cpu_execute_subset #(
  parameter int MEM_ADDR_BITS = cpux_pkg::MEM_ADDR_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  cpux_in_if.sink    in_ch,
  cpux_out_if.source out_ch
);
  import cpux_pkg::*;

  localparam int AW = MEM_ADDR_BITS;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_ADDR  = 8'b0000_0100,
    ST_RLO   = 8'b0000_1000,
    ST_RHI   = 8'b0001_0000,
    ST_CAP   = 8'b0010_0000,
    ST_EXEC  = 8'b0100_0000,
    ST_WHI   = 8'b1000_0000
  } state_t;

  state_t        state;
  logic [AW-1:0] clr_addr;
  item_t         item;
  word_t         ea, ea_next, disp_part;
  logic [7:0]    lo_byte, hi_byte, whi_data;
  logic          whi_pending;
  gpr_t          gpr;
  seg_t          seg;
  logic          zf, sf;
  word_t         ip;
  logic          out_valid;
  logic          go;
  logic [AW-1:0] lo_addr, hi_addr;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;
  exec_t         ex;

  assign in_ch.ready  = (state == ST_IDLE);
  assign out_ch.valid = out_valid;
  assign go           = !out_valid || out_ch.ready;
  assign lo_addr      = AW'(ea);
  assign hi_addr      = lo_addr + AW'(1);

  // Effective address from base and index registers plus displacement, or the displacement alone for a direct address.
  always_comb begin
    disp_part = (item.mode == 2'd0) ? 16'h0000 : item.displacement;
    case (item.rm_index)
      3'd0: ea_next = disp_part + gpr[REG_BX] + gpr[REG_SI];
      3'd1: ea_next = disp_part + gpr[REG_BX] + gpr[REG_DI];
      3'd2: ea_next = disp_part + gpr[REG_BP] + gpr[REG_SI];
      3'd3: ea_next = disp_part + gpr[REG_BP] + gpr[REG_DI];
      3'd4: ea_next = disp_part + gpr[REG_SI];
      3'd5: ea_next = disp_part + gpr[REG_DI];
      3'd6: ea_next = disp_part + gpr[REG_BP];
      default: ea_next = disp_part + gpr[REG_BX];
    endcase
    if (item.direct_address) ea_next = item.displacement;
  end

  cpux_alu u_alu (
    .item     (item),
    .gpr      (gpr),
    .seg      (seg),
    .zf       (zf),
    .sf       (sf),
    .ip       (ip),
    .mem_word ({hi_byte, lo_byte}),
    .res      (ex)
  );

  // Memory port control per sequencer state.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = lo_addr;
    ram_wdata = 8'h00;
    case (state)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_addr;
      end
      ST_RHI: ram_addr = hi_addr;
      ST_EXEC: begin
        ram_we    = go && ex.mem_we;
        ram_wdata = ex.value[7:0];
      end
      ST_WHI: begin
        ram_we    = whi_pending;
        ram_addr  = hi_addr;
        ram_wdata = whi_data;
      end
      default: ;
    endcase
  end

  cpux_ram #(.AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Sequencer and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      gpr         <= '0;
      seg         <= '0;
      zf          <= 1'b0;
      sf          <= 1'b0;
      ip          <= '0;
      out_valid   <= 1'b0;
      whi_pending <= 1'b0;
    end else begin
      // In execute a taken result is replaced by the new one below.
      if (out_valid && out_ch.ready && (state != ST_EXEC)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (&clr_addr) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_ch.valid) begin
            item.command        <= in_ch.command;
            item.to_register    <= in_ch.to_register;
            item.wide           <= in_ch.wide;
            item.mode           <= in_ch.mode;
            item.direct_address <= in_ch.direct_address;
            item.reg_index      <= in_ch.reg_index;
            item.rm_index       <= in_ch.rm_index;
            item.seg_index      <= in_ch.seg_index;
            item.displacement   <= in_ch.displacement;
            item.immediate      <= in_ch.immediate;
            state               <= ST_ADDR;
          end
        end
        ST_ADDR: begin
          ea    <= ea_next;
          state <= ST_RLO;
        end
        ST_RLO: state <= ST_RHI;
        ST_RHI: begin
          lo_byte <= ram_rdata;
          state   <= ST_CAP;
        end
        ST_CAP: begin
          hi_byte <= ram_rdata;
          state   <= ST_EXEC;
        end
        ST_EXEC: begin
          if (go) begin
            gpr                  <= ex.gpr;
            seg                  <= ex.seg;
            zf                   <= ex.zf;
            sf                   <= ex.sf;
            ip                   <= ex.ip;
            out_valid            <= 1'b1;
            out_ch.zero_flag     <= ex.zf;
            out_ch.sign_flag     <= ex.sf;
            out_ch.written_value <= ex.value;
            out_ch.branch_taken  <= ex.taken;
            out_ch.ip_value      <= ex.ip;
            whi_pending          <= ex.mem_we && item.wide;
            whi_data             <= ex.value[15:8];
            state                <= ST_WHI;
          end
        end
        ST_WHI: state <= ST_IDLE;
        default: state <= ST_CLEAR;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/cpux_checker.sv]
// Port-level checker for the execute block, bound to the top level.
// Depends on sixteen_bit_cpu_execute_subset_macros.svh.
`default_nettype none

`include "sixteen_bit_cpu_execute_subset_macros.svh"

module cpux_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        zero_flag,
  input logic        branch_taken,
  input logic [15:0] written_value
);

  // A taken branch only happens with the zero flag clear and writes nothing.
  `CPUX_ASSERT_IMP(a_taken_nz, out_valid && branch_taken, !zero_flag)
  `CPUX_ASSERT_IMP(a_taken_no_value, out_valid && branch_taken, written_value == 16'h0000)
  // One instruction in flight: ready drops after an input transaction.
  `CPUX_ASSERT_NEXT(a_single_item, in_valid && in_ready, !in_ready)
  // A held result stays valid until taken.
  `CPUX_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

endmodule

bind sixteen_bit_cpu_execute_subset cpux_checker u_cpux_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .zero_flag     (out_ch.zero_flag),
  .branch_taken  (out_ch.branch_taken),
  .written_value (out_ch.written_value)
);

`default_nettype wire
